### src/mdcg_pkg.sv
// ----------------------------------------------------------------------------
// Minimum distance code generator package
// Default parameters, port field widths and the popcount helper.
// ----------------------------------------------------------------------------
package mdcg_pkg;

  localparam int MAX_WORD_BITS_DEF = 8;
  localparam int MAX_CODES_DEF     = 64;
  localparam int WORD_BITS_LIMIT   = 12;

  localparam int CODE_COUNT_W   = 7;
  localparam int WORD_BITS_W    = 4;
  localparam int MIN_DIST_W     = 4;
  localparam int CODE_WORD_W    = 8;
  localparam int IN_TDATA_W     = 16;

  function automatic logic [3:0] popcount12(input logic [WORD_BITS_LIMIT-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS_LIMIT; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

### src/mdcg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mdcg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/min_distance_code_generator.sv
// ----------------------------------------------------------------------------
// Minimum distance code generator
// Greedy lexicographic code search over an exclusion bitmap held in RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (low bit up)                      | tlast | tuser
//  in_     | slave     | code_count, word_bits, min_distance, 0  | -     | -
//  out_    | master    | code_word                               | last  | exhausted
//
//  A request of S = 2^word_bits words first clears the bitmap word by word,
//  then tests each candidate word in a read state and a check state, takes
//  each found word through a found state and an emit state, and after each
//  found word but the last sweeps all S words to mark its neighbors. The
//  single bitmap RAM port pair sets how long a request takes.
//  Reset returns the sequencer to idle and drops any pending result.
//  A stalled output holds the sequencer at its next emitted word.
// ----------------------------------------------------------------------------
module min_distance_code_generator #(
  parameter int MAX_WORD_BITS = mdcg_pkg::MAX_WORD_BITS_DEF,
  parameter int MAX_CODES     = mdcg_pkg::MAX_CODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // code_count[6:0], word_bits[10:7], min_distance[14:11], zero pad[15]
  input  logic [mdcg_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // code_word[7:0]
  output logic [mdcg_pkg::CODE_WORD_W-1:0]  out_tdata,
  output logic                              out_tlast,
  // exhausted[0]
  output logic                              out_tuser
);

  localparam int AW    = MAX_WORD_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_CODES + 1);

  typedef enum logic [2:0] {
    IDLE, CLEAR, SCAN_RD, SCAN_CHK, FOUND, MARK, EMIT
  } state_t;

  state_t                               state_r, state_nxt, ret_r, ret_nxt;
  logic [AW:0]                          space_r, space_nxt;
  logic [AW:0]                          idx_r, idx_nxt;
  logic [AW:0]                          cand_r, cand_nxt;
  logic [CW-1:0]                        count_r, count_nxt;
  logic [CW-1:0]                        found_r, found_nxt;
  logic [mdcg_pkg::MIN_DIST_W-1:0]      dist_r, dist_nxt;
  logic [AW-1:0]                        prev_r, prev_nxt;
  logic                                 have_prev_r, have_prev_nxt;
  logic [AW-1:0]                        em_word_r, em_word_nxt;
  logic                                 em_last_r, em_last_nxt;
  logic                                 em_exh_r, em_exh_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [AW-1:0]                        out_word_r, out_word_nxt;
  logic                                 out_last_r, out_last_nxt;
  logic                                 out_exh_r, out_exh_nxt;

  logic                                 ram_we;
  logic                                 ram_rd;
  logic                                 near;
  logic [mdcg_pkg::CODE_COUNT_W-1:0]    in_count;
  logic [mdcg_pkg::WORD_BITS_W-1:0]     in_bits;
  logic [mdcg_pkg::MIN_DIST_W-1:0]      in_dist;

  assign in_count = in_tdata[6:0];
  assign in_bits  = in_tdata[10:7];
  assign in_dist  = in_tdata[14:11];

  assign near = mdcg_pkg::popcount12(
                  mdcg_pkg::WORD_BITS_LIMIT'(idx_r[AW-1:0] ^ cand_r[AW-1:0])) < dist_r;

  assign ram_we = (state_r == CLEAR) || ((state_r == MARK) && near);

  mdcg_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_r[AW-1:0]),
    .wr_data (state_r == MARK),
    .rd_addr (cand_r[AW-1:0]),
    .rd_data (ram_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    space_nxt     = space_r;
    idx_nxt       = idx_r;
    cand_nxt      = cand_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    dist_nxt      = dist_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    em_word_nxt   = em_word_r;
    em_last_nxt   = em_last_r;
    em_exh_nxt    = em_exh_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_exh_nxt   = out_exh_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      IDLE: begin
        if (in_tvalid) begin
          if (int'(in_count) > MAX_CODES) begin
            count_nxt = CW'(MAX_CODES);
          end else begin
            count_nxt = CW'(in_count);
          end
          if (int'(in_bits) > MAX_WORD_BITS) begin
            space_nxt = (AW + 1)'(1) << AW;
          end else begin
            space_nxt = (AW + 1)'(1) << in_bits;
          end
          dist_nxt      = (in_dist == '0) ? mdcg_pkg::MIN_DIST_W'(1) : in_dist;
          idx_nxt       = '0;
          cand_nxt      = '0;
          found_nxt     = '0;
          have_prev_nxt = 1'b0;
          if (in_count != '0) begin
            state_nxt = CLEAR;
          end
        end
      end
      CLEAR: begin
        idx_nxt = idx_r + (AW + 1)'(1);
        if (idx_r == space_r - (AW + 1)'(1)) begin
          cand_nxt  = '0;
          state_nxt = SCAN_RD;
        end
      end
      SCAN_RD: begin
        if (cand_r == space_r) begin
          em_word_nxt   = prev_r;
          em_last_nxt   = 1'b1;
          em_exh_nxt    = 1'b1;
          have_prev_nxt = 1'b0;
          ret_nxt       = IDLE;
          state_nxt     = EMIT;
        end else begin
          state_nxt = SCAN_CHK;
        end
      end
      SCAN_CHK: begin
        if (ram_rd) begin
          cand_nxt  = cand_r + (AW + 1)'(1);
          state_nxt = SCAN_RD;
        end else begin
          found_nxt = found_r + CW'(1);
          if (have_prev_r) begin
            em_word_nxt = prev_r;
            em_last_nxt = 1'b0;
            em_exh_nxt  = 1'b0;
            ret_nxt     = FOUND;
            state_nxt   = EMIT;
          end else begin
            state_nxt = FOUND;
          end
        end
      end
      FOUND: begin
        if (found_r == count_r) begin
          em_word_nxt   = cand_r[AW-1:0];
          em_last_nxt   = 1'b1;
          em_exh_nxt    = 1'b0;
          have_prev_nxt = 1'b0;
          ret_nxt       = IDLE;
          state_nxt     = EMIT;
        end else begin
          prev_nxt      = cand_r[AW-1:0];
          have_prev_nxt = 1'b1;
          idx_nxt       = '0;
          state_nxt     = MARK;
        end
      end
      MARK: begin
        idx_nxt = idx_r + (AW + 1)'(1);
        if (idx_r == space_r - (AW + 1)'(1)) begin
          state_nxt = SCAN_RD;
        end
      end
      EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = em_word_r;
          out_last_nxt  = em_last_r;
          out_exh_nxt   = em_exh_r;
          state_nxt     = ret_r;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      ret_r       <= IDLE;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    space_r    <= space_nxt;
    idx_r      <= idx_nxt;
    cand_r     <= cand_nxt;
    count_r    <= count_nxt;
    found_r    <= found_nxt;
    dist_r     <= dist_nxt;
    prev_r     <= prev_nxt;
    em_word_r  <= em_word_nxt;
    em_last_r  <= em_last_nxt;
    em_exh_r   <= em_exh_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  assign in_tready  = (state_r == IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = mdcg_pkg::CODE_WORD_W'(out_word_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_exh_r;

  a_exh_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("exhausted flag on a result that is not final");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FOUND) |-> (found_r <= count_r) && (found_r != '0))
    else $error("found word count out of range");

  a_exhaust_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN_RD) && (cand_r == space_r) |-> have_prev_r)
    else $error("space ran out with no word held");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MARK) || (state_r == CLEAR) |-> (idx_r < space_r))
    else $error("bitmap sweep beyond word space");

  a_scan_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN_CHK) |-> $past(state_r) == SCAN_RD)
    else $error("bitmap checked without a read");

endmodule

### dv/lexicode_checker.sv
// ----------------------------------------------------------------------------
// Lexicode checker
// Watches the request and code word channels of the minimum distance code
// generator. Every accepted request is expanded into the greedy lexicographic
// code it asks for. Every accepted code word is compared field by field with
// the oldest word still owed.
// ----------------------------------------------------------------------------
module lexicode_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // code_count[6:0], word_bits[10:7], min_distance[14:11], zero pad[15]
  input  logic [mdcg_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // code_word[7:0]
  input  logic [mdcg_pkg::CODE_WORD_W-1:0]    out_tdata,
  input  logic                                out_tlast,
  // exhausted[0]
  input  logic                                out_tuser,
  output int                                  fail_count,
  output int                                  words_owed
);

  typedef struct packed {
    logic [mdcg_pkg::CODE_WORD_W-1:0] code_word;
    logic                             last;
    logic                             exhausted;
  } code_word_t;

  code_word_t lexicode_q[$];

  initial begin
    fail_count = 0;
    words_owed = 0;
  end

  function automatic void build_lexicode(
    input logic [mdcg_pkg::CODE_COUNT_W-1:0] count_f,
    input logic [mdcg_pkg::WORD_BITS_W-1:0]  bits_f,
    input logic [mdcg_pkg::MIN_DIST_W-1:0]   dist_f
  );
    int          count;
    int          bits;
    int          min_dist;
    int          space;
    int          cand;
    bit          ran_out;
    bit          excluded [256];
    logic [7:0]  words [$];
    code_word_t  item;

    count    = (count_f > mdcg_pkg::MAX_CODES_DEF) ? mdcg_pkg::MAX_CODES_DEF : int'(count_f);
    bits     = (bits_f > mdcg_pkg::MAX_WORD_BITS_DEF) ? mdcg_pkg::MAX_WORD_BITS_DEF
                                                     : int'(bits_f);
    min_dist = (dist_f == 0) ? 1 : int'(dist_f);
    space    = 1 << bits;
    ran_out  = 1'b0;
    cand     = 0;
    foreach (excluded[i]) excluded[i] = 1'b0;

    while (words.size() < count) begin
      while (cand < space && excluded[cand]) cand++;
      if (cand >= space) begin
        ran_out = 1'b1;
        break;
      end
      words.push_back(8'(cand));
      for (int x = 0; x < space; x++) begin
        if ($countones(x ^ cand) < min_dist) excluded[x] = 1'b1;
      end
    end

    foreach (words[k]) begin
      item.code_word = words[k];
      item.last      = (k == words.size() - 1);
      item.exhausted = item.last && ran_out;
      lexicode_q.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    code_word_t owed;
    if (rst_n) begin
      // The word leaving now always belongs to an earlier request, so it is
      // checked before a request accepted at the same edge is expanded.
      if (out_tvalid && out_tready) begin
        if (lexicode_q.size() == 0) begin
          $error("code_word: expected none, actual %0d", out_tdata);
          fail_count++;
        end else begin
          owed = lexicode_q.pop_front();
          if (out_tdata !== owed.code_word) begin
            $error("code_word: expected %0d, actual %0d", owed.code_word, out_tdata);
            fail_count++;
          end
          if (out_tlast !== owed.last) begin
            $error("last: expected %0d, actual %0d", owed.last, out_tlast);
            fail_count++;
          end
          if (out_tuser !== owed.exhausted) begin
            $error("exhausted: expected %0d, actual %0d", owed.exhausted, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        build_lexicode(in_tdata[6:0], in_tdata[10:7], in_tdata[14:11]);
      end
      words_owed <= lexicode_q.size();
    end
  end

endmodule

### dv/min_distance_code_generator_tb.sv
// ----------------------------------------------------------------------------
// Minimum distance code generator testbench
// Sends directed corner requests and then random ones with random gaps on
// both channels. A separate checker predicts the code words and counts
// mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module min_distance_code_generator_tb;

  localparam int RANDOM_REQUESTS = 123;
  localparam int IDLE_LIMIT      = 40000;
  localparam int DRAIN_CYCLES    = 600;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [mdcg_pkg::IN_TDATA_W-1:0]    in_tdata   = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [mdcg_pkg::CODE_WORD_W-1:0]   out_tdata;
  logic                               out_tlast;
  logic                               out_tuser;
  int                                 fail_count;
  int                                 words_owed;
  int                                 idle_cycles = 0;
  bit                                 send_calm   = 1'b0;
  bit                                 take_calm   = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  min_distance_code_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  lexicode_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  task automatic send_request(input int count, input int bits, input int min_dist);
    int gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, 4'(min_dist), 4'(bits), 7'(count)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_request();
    int count;
    int bits;
    int min_dist;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      bits = $urandom_range(0, 5);
    end else if (pick < 95) begin
      bits = $urandom_range(6, 8);
    end else begin
      bits = $urandom_range(9, 15);
    end
    pick = $urandom_range(0, 99);
    min_dist = (pick < 70) ? $urandom_range(1, 4) : $urandom_range(0, 15);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      count = $urandom_range(1, 20);
    end else if (pick < 85) begin
      count = $urandom_range(21, 64);
    end else begin
      count = $urandom_range(0, 127);
    end
    send_request(count, bits, min_dist);
  endtask

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero count, zero width, exact fit, zero distance,
    // distance beyond the width, saturated count and width, dense codes.
    send_request(0, 3, 2);
    send_request(1, 0, 1);
    send_request(3, 0, 1);
    send_request(2, 1, 1);
    send_request(3, 1, 1);
    send_request(10, 3, 0);
    send_request(4, 4, 15);
    send_request(4, 8, 8);
    send_request(64, 8, 1);
    send_request(127, 8, 1);
    send_request(5, 15, 3);
    send_request(1, 15, 15);
    send_request(64, 7, 3);
    send_request(64, 6, 4);
    send_request(127, 2, 2);
    send_request(64, 5, 2);
    send_request(65, 4, 9);

    repeat (RANDOM_REQUESTS) send_random_request();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### min_distance_code_generator.f
src/mdcg_pkg.sv
src/mdcg_ram.sv
src/min_distance_code_generator.sv
dv/lexicode_checker.sv
dv/min_distance_code_generator_tb.sv
